// ----- rtl/ccm_pkg.sv -----
// ----------------------------------------------------------------------------
// ccm_pkg: shared types, constants and AES byte functions
// Holds the S-box, GF(2^8) helpers, verdict codes and the command queue entry.
// ----------------------------------------------------------------------------
package ccm_pkg;

    localparam logic [2:0] VERDICT_BAD_TAG = 3'd0;
    localparam logic [2:0] VERDICT_REPLAY  = 3'd1;
    localparam logic [2:0] VERDICT_UNLOCK  = 3'd2;
    localparam logic [2:0] VERDICT_LOCK    = 3'd3;
    localparam logic [2:0] VERDICT_UNKNOWN = 3'd4;

    localparam logic [7:0] ACT_UNLOCK = 8'h01;
    localparam logic [7:0] ACT_LOCK   = 8'h02;

    localparam logic [7:0] B0_FLAGS = 8'h09;
    localparam logic [7:0] A0_FLAGS = 8'h01;
    localparam logic [7:0] MSG_LEN  = 8'h07;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    // Packet as it travels from the input side to the crypto side
    typedef struct packed {
        logic [15:0] sender_id;
        logic [31:0] sequence_req;
        logic [7:0]  action_code;
        logic [31:0] tag;
    } pkt_t;

    // Finished MAC comparison handed to the replay check
    typedef struct packed {
        logic [15:0] sender_id;
        logic [31:0] sequence_req;
        logic [7:0]  action_code;
        logic        tag_ok;
    } chk_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_B0,
        ENG_MSG,
        ENG_A0
    } eng_state_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        unique case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a 128-bit block sits in bits [127-8i -: 8]
    function automatic logic [7:0] blk_byte(input logic [127:0] b, input int i);
        return b[127 - 8*i -: 8];
    endfunction

    // One AES round without the key add; last drops MixColumns
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[c*4+i] = sbox(blk_byte(s, ((c + i) % 4) * 4 + i));
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o[127 - 8*i -: 8] = t[i];
        end
        return o;
    endfunction

    // Next round key from the previous one and its round constant
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, tw;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        tw = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ tw;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ----- rtl/ccm_front.sv -----
// ----------------------------------------------------------------------------
// ccm_front: input register and two-entry packet queue
// Takes packets from the stream and holds them until the engine is free.
// ----------------------------------------------------------------------------
module ccm_front import ccm_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  pkt_t in_pkt,
    output logic q_valid,
    input  logic q_ready,
    output pkt_t q_pkt
);
    pkt_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_pkt    = mem_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_pkt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 |-> !pop) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
`endif
endmodule

// ----- rtl/ccm_engine.sv -----
// ----------------------------------------------------------------------------
// ccm_engine: iterative AES-128 core running the three CCM encryptions
// One round per cycle but for a result stall; round keys expanded on the fly.
// ----------------------------------------------------------------------------
module ccm_engine import ccm_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [127:0] key,
    input  logic         q_valid,
    output logic         q_ready,
    input  pkt_t         q_pkt,
    output logic         c_valid,
    input  logic         c_ready,
    output chk_t         c_data
);
    eng_state_t   state_reg, state_next;
    logic [3:0]   round_reg, round_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] rk_reg, rk_next;
    logic [7:0]   rc_reg, rc_next;
    logic [127:0] x1_reg, x1_next;
    logic [127:0] x2_reg, x2_next;
    pkt_t         pkt_reg;
    logic         c_valid_reg, c_valid_next;
    chk_t         c_data_reg, c_data_next;

    logic [103:0] nonce;
    logic [127:0] b0, a0, msg, nk, rnd, res, start_blk;
    logic         start, load;
    logic [31:0]  calc;

    assign nonce = {pkt_reg.sender_id[7:0], pkt_reg.sender_id[15:8],
                    pkt_reg.sequence_req[7:0], pkt_reg.sequence_req[15:8],
                    pkt_reg.sequence_req[23:16], pkt_reg.sequence_req[31:24], 56'd0};
    assign b0  = {B0_FLAGS, nonce, 8'h00, MSG_LEN};
    assign a0  = {A0_FLAGS, nonce, 16'h0000};
    assign msg = {pkt_reg.sender_id[7:0], pkt_reg.sender_id[15:8],
                  pkt_reg.sequence_req[7:0], pkt_reg.sequence_req[15:8],
                  pkt_reg.sequence_req[23:16], pkt_reg.sequence_req[31:24],
                  pkt_reg.action_code, 72'd0};

    assign nk  = key_step(rk_reg, rc_reg);
    assign rnd = aes_round(st_reg, round_reg == 4'd10) ^ nk;
    assign res = rnd;

    assign q_ready = (state_reg == ENG_IDLE);
    assign start   = q_valid && q_ready;
    assign c_valid = c_valid_reg;
    assign c_data  = c_data_reg;

    always_ff @(posedge aclk) begin
        if (start) pkt_reg <= q_pkt;
    end

    always_comb begin
        state_next   = state_reg;
        round_next   = round_reg;
        st_next      = st_reg;
        rk_next      = rk_reg;
        rc_next      = rc_reg;
        x1_next      = x1_reg;
        x2_next      = x2_reg;
        c_valid_next = c_valid_reg;
        c_data_next  = c_data_reg;
        load         = 1'b0;
        start_blk    = b0;
        calc         = '0;
        if (c_valid_reg && c_ready) c_valid_next = 1'b0;
        unique case (state_reg)
            ENG_IDLE: begin
                if (start) begin
                    state_next = ENG_B0;
                    load       = 1'b1;
                    round_next = 4'd0;
                end
            end
            ENG_B0, ENG_MSG, ENG_A0: begin
                if (round_reg == 4'd0) begin
                    // initial key add of the chosen block
                    if (state_reg == ENG_MSG) start_blk = msg ^ x1_reg;
                    else if (state_reg == ENG_A0) start_blk = a0;
                    else start_blk = b0;
                    st_next    = start_blk ^ key;
                    rk_next    = key;
                    rc_next    = 8'h01;
                    round_next = 4'd1;
                end else begin
                    st_next    = rnd;
                    rk_next    = nk;
                    rc_next    = xtime(rc_reg);
                    round_next = round_reg + 4'd1;
                    if (round_reg == 4'd10) begin
                        round_next = 4'd0;
                        if (state_reg == ENG_B0) begin
                            x1_next    = res;
                            state_next = ENG_MSG;
                        end else if (state_reg == ENG_MSG) begin
                            x2_next    = res;
                            state_next = ENG_A0;
                        end else if (!c_valid_reg || c_ready) begin
                            // tag bytes 0..3 from the left of X2 xor S0
                            for (int i = 0; i < 4; i++) begin
                                calc[8*i +: 8] = blk_byte(x2_reg, i) ^ blk_byte(res, i);
                            end
                            c_data_next.sender_id    = pkt_reg.sender_id;
                            c_data_next.sequence_req = pkt_reg.sequence_req;
                            c_data_next.action_code  = pkt_reg.action_code;
                            c_data_next.tag_ok       = (calc == pkt_reg.tag);
                            c_valid_next = 1'b1;
                            state_next   = ENG_IDLE;
                        end else begin
                            // hold the last round until the result slot frees
                            st_next    = st_reg;
                            rk_next    = rk_reg;
                            rc_next    = rc_reg;
                            round_next = round_reg;
                        end
                    end
                end
            end
            default: state_next = ENG_IDLE;
        endcase
        if (load) st_next = st_reg;
    end

    always_ff @(posedge aclk) begin
        st_reg     <= st_next;
        rk_reg     <= rk_next;
        rc_reg     <= rc_next;
        x1_reg     <= x1_next;
        x2_reg     <= x2_next;
        c_data_reg <= c_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ENG_IDLE;
            round_reg   <= 4'd0;
            c_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            c_valid_reg <= c_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        round_reg <= 4'd10) else $error("round counter out of range");
    a_idle_round: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ENG_IDLE |-> round_reg == 4'd0) else $error("idle with round");
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && !c_ready |=> c_valid_reg && $stable(c_data_reg))
        else $error("result dropped");
`endif
endmodule

// ----- rtl/ccm_back.sv -----
// ----------------------------------------------------------------------------
// ccm_back: replay check, state update and output register
// ----------------------------------------------------------------------------
module ccm_back import ccm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       c_valid,
    output logic       c_ready,
    input  chk_t       c_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_verdict,
    output logic       m_fire
);
    logic [15:0] last_sender_reg;
    logic [31:0] last_sequence_reg;
    logic        m_valid_reg;
    logic [2:0]  verdict_reg, verdict_next;
    logic        fire_reg, fire_next;
    logic [31:0] last;
    logic        take;

    assign c_ready   = !m_valid_reg || m_ready;
    assign take      = c_valid && c_ready;
    assign m_valid   = m_valid_reg;
    assign m_verdict = verdict_reg;
    assign m_fire    = fire_reg;

    always_comb begin
        last = (c_data.sender_id == last_sender_reg) ? last_sequence_reg : 32'd0;
        fire_next = 1'b0;
        priority if (!c_data.tag_ok) begin
            verdict_next = VERDICT_BAD_TAG;
        end else if (c_data.sequence_req <= last) begin
            verdict_next = VERDICT_REPLAY;
        end else if (c_data.action_code == ACT_UNLOCK) begin
            verdict_next = VERDICT_UNLOCK;
            fire_next    = 1'b1;
        end else if (c_data.action_code == ACT_LOCK) begin
            verdict_next = VERDICT_LOCK;
            fire_next    = 1'b1;
        end else begin
            verdict_next = VERDICT_UNKNOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            verdict_reg <= verdict_next;
            fire_reg    <= fire_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg       <= 1'b0;
            last_sender_reg   <= 16'd0;
            last_sequence_reg <= 32'd0;
        end else begin
            if (take) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            if (take && fire_next) begin
                last_sender_reg   <= c_data.sender_id;
                last_sequence_reg <= c_data.sequence_req;
            end
        end
    end

`ifndef SYNTHESIS
    a_fire_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && fire_reg |-> verdict_reg == VERDICT_UNLOCK || verdict_reg == VERDICT_LOCK)
        else $error("fire without unlock or lock");
    a_state_update: assert property (@(posedge aclk) disable iff (!aresetn)
        take && fire_next |=> last_sequence_reg == $past(c_data.sequence_req))
        else $error("state not updated");
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(take && fire_next) |=> $stable(last_sequence_reg) && $stable(last_sender_reg))
        else $error("state changed without fire");
`endif
endmodule

// ----- rtl/ccm_mic_command_verifier.sv -----
// ----------------------------------------------------------------------------
// ccm_mic_command_verifier: CCM tag and replay check of key fob commands
//
//   channel | dir | handshake            | contents
//   s_      | in  | s_tvalid / s_tready  | packet: id, counter, command, tag
//   m_      | out | m_tvalid / m_tready  | verdict and fire
//   cfg_    | in  | cfg_we               | key halves
//
// A packet holds the AES core for three encryptions, each a key add and
// ten rounds, plus an idle state in which the core takes the next packet
// from the queue. The single shared round unit takes no new packet until
// it is through with the last one.
// A two-entry queue in front and a result register behind let the input
// and output sides stall on their own. Reset is synchronous, active low,
// and clears the stored sender and counter.
// ----------------------------------------------------------------------------
module ccm_mic_command_verifier import ccm_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] sender_id, [47:16] sequence_req, [55:48] action_code, [87:56] tag
    input  logic [87:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] verdict, [3] fire, [7:4] zero
    output logic [7:0]   m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data
);
    logic [63:0] key_high_reg, key_low_reg;
    pkt_t        in_pkt, q_pkt;
    logic        q_valid, q_ready, c_valid, c_ready, fire;
    chk_t        c_data;
    logic [2:0]  verdict;

    // Hold the key; index 0 is the high half
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= 64'd0;
            key_low_reg  <= 64'd0;
        end else if (cfg_we) begin
            if (cfg_index == CFG_KEY_HIGH) key_high_reg <= cfg_data;
            if (cfg_index == CFG_KEY_LOW)  key_low_reg  <= cfg_data;
        end
    end

    assign in_pkt.sender_id    = s_tdata[15:0];
    assign in_pkt.sequence_req = s_tdata[47:16];
    assign in_pkt.action_code  = s_tdata[55:48];
    assign in_pkt.tag          = s_tdata[87:56];

    ccm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_pkt(in_pkt),
        .q_valid(q_valid), .q_ready(q_ready), .q_pkt(q_pkt)
    );

    ccm_engine u_engine (
        .aclk(aclk), .aresetn(aresetn), .key({key_high_reg, key_low_reg}),
        .q_valid(q_valid), .q_ready(q_ready), .q_pkt(q_pkt),
        .c_valid(c_valid), .c_ready(c_ready), .c_data(c_data)
    );

    ccm_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .c_valid(c_valid), .c_ready(c_ready), .c_data(c_data),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_verdict(verdict), .m_fire(fire)
    );

    assign m_tdata = {4'd0, fire, verdict};
endmodule
